FILE: sv/colon_record_field_parser_top_assert.svh
// ----------------------------------------------------------------------------
// colon record field parser assertion macros
// concurrent checks sampled on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef COLON_RECORD_FIELD_PARSER_TOP_ASSERT_SVH
`define COLON_RECORD_FIELD_PARSER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CPRF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CPRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cprf_pkg.sv
// ----------------------------------------------------------------------------
// cprf_pkg
// types and constants of the colon record field parser
// ----------------------------------------------------------------------------
package cprf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FIELD_W  = 3;
    localparam int unsigned OFFSET_W = 16;
    localparam int unsigned ID_W     = 17;
    localparam int unsigned TOTAL_W  = 17;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned BUFLEN_W = 16;

    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [FIELD_W-1:0]  t_field;
    typedef logic [OFFSET_W-1:0] t_offset;
    typedef logic [ID_W-1:0]     t_id;
    typedef logic [TOTAL_W-1:0]  t_total;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [BUFLEN_W-1:0] t_buflen;

    // field codes
    localparam t_field FLD_NAME    = 3'd0;
    localparam t_field FLD_PASSWD  = 3'd1;
    localparam t_field FLD_UID     = 3'd2;
    localparam t_field FLD_GID     = 3'd3;
    localparam t_field FLD_COMMENT = 3'd4;
    localparam t_field FLD_HOME    = 3'd5;
    localparam t_field FLD_SHELL   = 3'd6;
    localparam t_field FLD_EXTRA   = 3'd7;

    localparam t_byte   SEP_CHAR      = 8'h3A;
    localparam t_byte   NL_CHAR       = 8'h0A;
    localparam t_byte   ASCII_ZERO    = 8'h30;
    localparam t_byte   ASCII_NINE    = 8'h39;
    localparam t_field  COLONS_NEEDED = 3'd6;
    localparam t_cnt    MAX_DIGITS    = 3'd5;
    localparam t_cnt    DIGIT_CNT_MAX = 3'd7;
    localparam t_total  TOTAL_MAX     = 17'h1FFFF;
    localparam t_offset OFFSET_MAX    = 16'hFFFF;
    localparam t_buflen BUFLEN_RESET  = 16'd1024;
    localparam logic [3:0] RADIX      = 4'd10;
    localparam logic [2:0] TERM_GAPS  = 3'd5;

    typedef struct packed {
        t_field  field_number;
        t_byte   char_out;
        logic    is_content;
        t_offset buffer_offset;
        logic    record_done;
        logic    status;
        t_id     user_id;
        t_id     group_id;
    } t_result;

    function automatic logic is_string_field(input t_field f);
        return (f == FLD_NAME) || (f == FLD_PASSWD) || (f == FLD_COMMENT) ||
               (f == FLD_HOME) || (f == FLD_SHELL);
    endfunction

    // number of string fields ahead of this one, i.e. terminator gaps so far
    function automatic logic [2:0] string_ordinal(input t_field f);
        logic [2:0] ord;
        case (f)
            FLD_PASSWD:  ord = 3'd1;
            FLD_COMMENT: ord = 3'd2;
            FLD_HOME:    ord = 3'd3;
            FLD_SHELL:   ord = 3'd4;
            default:     ord = 3'd0;
        endcase
        return ord;
    endfunction

endpackage

FILE: sv/cprf_in_if.sv
// ----------------------------------------------------------------------------
// cprf_in_if
// byte input channel: one record byte and its last-byte flag per transfer
// ----------------------------------------------------------------------------
interface cprf_in_if;
    import cprf_pkg::*;

    logic  valid;
    logic  ready;
    t_byte char_in;
    logic  line_last;

    modport source (output valid, output char_in, output line_last, input ready);
    modport sink   (input valid, input char_in, input line_last, output ready);
endinterface

FILE: sv/cprf_out_if.sv
// ----------------------------------------------------------------------------
// cprf_out_if
// result channel: one parse result per input byte
// ----------------------------------------------------------------------------
interface cprf_out_if;
    import cprf_pkg::*;

    logic    valid;
    logic    ready;
    t_field  field_number;
    t_byte   char_out;
    logic    is_content;
    t_offset buffer_offset;
    logic    record_done;
    logic    status;
    t_id     user_id;
    t_id     group_id;

    modport source (
        output valid, output field_number, output char_out, output is_content,
        output buffer_offset, output record_done, output status,
        output user_id, output group_id, input ready
    );
    modport sink (
        input valid, input field_number, input char_out, input is_content,
        input buffer_offset, input record_done, input status,
        input user_id, input group_id, output ready
    );
endinterface

FILE: sv/cprf_cfg_if.sv
// ----------------------------------------------------------------------------
// cprf_cfg_if
// configuration write channel for the buffer length register
// ----------------------------------------------------------------------------
interface cprf_cfg_if;
    import cprf_pkg::*;

    logic    valid;
    logic    ready;
    t_buflen buffer_length;

    modport source (output valid, output buffer_length, input ready);
    modport sink   (input valid, input buffer_length, output ready);
endinterface

FILE: sv/colon_record_field_parser_top.sv
// ----------------------------------------------------------------------------
// colon_record_field_parser_top
// per-byte parser of seven-field colon separated account records
// ----------------------------------------------------------------------------
// usage:
//   i_in   takes one record byte per transfer with line_last on the final byte
//   o_out  gives one result per byte: field, content flag, packed offset, and
//          on the final byte record_done, status, user_id and group_id
//   i_cfg  writes buffer_length; always ready, write only while idle
// result: an accepted byte's result is registered in the output slot, or in
//   the skid slot if that is held; the field and number state update with it
// throughput: one byte per cycle while i_in.ready is high; the uid and gid
//   multiply-adds and overflow compare sit between state and result register
// stall: an output register plus a skid register; i_in.ready drops only
//   when both hold results, so a stalled receiver costs at most one byte
// reset: record state clears, both result slots empty, buffer_length 1024;
//   the block is ready as soon as reset is released
// ----------------------------------------------------------------------------
module colon_record_field_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cprf_in_if.sink    i_in,
    cprf_cfg_if.sink   i_cfg,
    cprf_out_if.source o_out
);
    import cprf_pkg::*;

    `include "colon_record_field_parser_top_assert.svh"

    // record state
    t_field  r_field;
    t_total  r_total;
    t_id     r_uid;
    t_id     r_gid;
    t_cnt    r_uid_cnt;
    t_cnt    r_gid_cnt;
    logic    r_bad;
    t_buflen r_buf_len;

    t_field  n_field;
    t_total  n_total;
    t_id     n_uid;
    t_id     n_gid;
    t_cnt    n_uid_cnt;
    t_cnt    n_gid_cnt;
    logic    n_bad;

    // output slot and skid slot
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    t_result n_res;

    logic        in_acc;
    logic        out_take;
    logic        is_digit;
    logic [3:0]  digit;
    logic [20:0] uid_mac;
    logic [20:0] gid_mac;
    logic [17:0] pos;
    logic [17:0] need;
    logic        final_nl;

    assign i_in.ready  = !r_skid_valid;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_take    = o_out.valid && o_out.ready;
    assign i_cfg.ready = 1'b1;

    assign is_digit = (i_in.char_in >= ASCII_ZERO) && (i_in.char_in <= ASCII_NINE);
    assign digit    = 4'(i_in.char_in - ASCII_ZERO);
    assign uid_mac  = {4'b0, r_uid} * {17'b0, RADIX} + {17'b0, digit};
    assign gid_mac  = {4'b0, r_gid} * {17'b0, RADIX} + {17'b0, digit};
    assign pos      = {1'b0, r_total} + {15'b0, string_ordinal(r_field)};
    assign final_nl = i_in.line_last && (r_field == FLD_SHELL) && (i_in.char_in == NL_CHAR);

    always_comb begin
        n_field   = r_field;
        n_total   = r_total;
        n_uid     = r_uid;
        n_gid     = r_gid;
        n_uid_cnt = r_uid_cnt;
        n_gid_cnt = r_gid_cnt;
        n_bad     = r_bad;

        n_res               = '0;
        n_res.field_number  = r_field;
        n_res.char_out      = i_in.char_in;

        if (i_in.char_in == SEP_CHAR) begin
            if (r_field != FLD_EXTRA) begin
                n_field = r_field + 3'd1;
            end
        end else if (r_field == FLD_UID) begin
            if (!is_digit) begin
                n_bad = 1'b1;
            end else begin
                // digits past the fifth are counted but not accumulated
                if (r_uid_cnt < MAX_DIGITS) begin
                    n_uid = uid_mac[ID_W-1:0];
                end
                if (r_uid_cnt != DIGIT_CNT_MAX) begin
                    n_uid_cnt = r_uid_cnt + 3'd1;
                end
            end
        end else if (r_field == FLD_GID) begin
            if (!is_digit) begin
                n_bad = 1'b1;
            end else begin
                if (r_gid_cnt < MAX_DIGITS) begin
                    n_gid = gid_mac[ID_W-1:0];
                end
                if (r_gid_cnt != DIGIT_CNT_MAX) begin
                    n_gid_cnt = r_gid_cnt + 3'd1;
                end
            end
        end else if (is_string_field(r_field) && !final_nl) begin
            n_res.is_content    = 1'b1;
            n_res.buffer_offset = (pos > {2'b0, OFFSET_MAX}) ? OFFSET_MAX
                                                               : pos[OFFSET_W-1:0];
            if (r_total != TOTAL_MAX) begin
                n_total = r_total + 17'd1;
            end
        end

        // string bytes plus one terminator per string field
        need = {1'b0, n_total} + {15'b0, TERM_GAPS};

        if (i_in.line_last) begin
            n_res.record_done = 1'b1;
            n_res.status      = n_bad || (n_field != COLONS_NEEDED) ||
                                (n_uid_cnt > MAX_DIGITS) || (n_gid_cnt > MAX_DIGITS) ||
                                (need >= {2'b0, r_buf_len});
            n_res.user_id     = n_uid;
            n_res.group_id    = n_gid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field   <= FLD_NAME;
            r_total   <= '0;
            r_uid     <= '0;
            r_gid     <= '0;
            r_uid_cnt <= '0;
            r_gid_cnt <= '0;
            r_bad     <= 1'b0;
        end else if (in_acc) begin
            if (i_in.line_last) begin
                r_field   <= FLD_NAME;
                r_total   <= '0;
                r_uid     <= '0;
                r_gid     <= '0;
                r_uid_cnt <= '0;
                r_gid_cnt <= '0;
                r_bad     <= 1'b0;
            end else begin
                r_field   <= n_field;
                r_total   <= n_total;
                r_uid     <= n_uid;
                r_gid     <= n_gid;
                r_uid_cnt <= n_uid_cnt;
                r_gid_cnt <= n_gid_cnt;
                r_bad     <= n_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_len <= BUFLEN_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_buf_len <= i_cfg.buffer_length;
        end
    end

    // result slots: new results fill the output slot when it frees up,
    // otherwise park in the skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (!r_out_valid || out_take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end else if (out_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.field_number  = r_out.field_number;
    assign o_out.char_out      = r_out.char_out;
    assign o_out.is_content    = r_out.is_content;
    assign o_out.buffer_offset = r_out.buffer_offset;
    assign o_out.record_done   = r_out.record_done;
    assign o_out.status        = r_out.status;
    assign o_out.user_id       = r_out.user_id;
    assign o_out.group_id      = r_out.group_id;

    `CPRF_ASSERT_SAME(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid slot full while output slot empty")
    `CPRF_ASSERT_NEXT(a_clear_after_last, in_acc && i_in.line_last,
        (r_field == FLD_NAME) && (r_total == '0) && !r_bad,
        "record state not cleared after last byte")
    `CPRF_ASSERT_SAME(a_ids_only_at_end, o_out.valid && !o_out.record_done,
        !o_out.status && (o_out.user_id == '0) && (o_out.group_id == '0),
        "record end fields set on a mid-record result")
    `CPRF_ASSERT_SAME(a_offset_only_content, o_out.valid && !o_out.is_content,
        o_out.buffer_offset == '0, "offset set on a non-content result")

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// colon record field parser testbench
// drives records byte by byte with random sender gaps and receiver stalls,
// predicts every result in the bench and checks each field in order across
// several buffer_length settings, from zero up to the largest value
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import cprf_pkg::*;

    localparam int unsigned WATCH_LIMIT = 2000;
    localparam int unsigned QUIET_ITEMS = 120;

    typedef struct packed {
        t_byte ch;
        logic  last;
    } t_line_byte;

    logic clk;
    logic rst_n;

    cprf_in_if  in_bus();
    cprf_out_if out_bus();
    cprf_cfg_if cfg_bus();

    colon_record_field_parser_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    t_line_byte  pending_bytes[$];
    t_line_byte  draft[$];
    t_result     expected_results[$];
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    logic        final_phase = 1'b0;

    // parser state as the bench sees it
    t_buflen buf_len    = BUFLEN_RESET;
    t_field  rec_field  = FLD_NAME;
    t_total  str_total  = '0;
    t_id     uid_acc    = '0;
    t_id     gid_acc    = '0;
    t_cnt    uid_digits = '0;
    t_cnt    gid_digits = '0;
    logic    rec_bad    = 1'b0;

    function automatic void add_digit(input t_byte ch, inout t_id acc, inout t_cnt cnt);
        if (ch < ASCII_ZERO || ch > ASCII_NINE) begin
            rec_bad = 1'b1;
        end else begin
            // digits past the fifth are counted but not accumulated
            if (cnt < MAX_DIGITS)
                acc = t_id'(32'(acc) * 32'(RADIX) + 32'(ch) - 32'(ASCII_ZERO));
            if (cnt != DIGIT_CNT_MAX)
                cnt = cnt + 1'b1;
        end
    endfunction

    function automatic t_result parse_byte(input t_byte ch, input logic last);
        t_result     res;
        t_field      fld;
        logic        str_field;
        int unsigned gaps;
        int unsigned pos;
        res = '0;
        fld = rec_field;
        res.field_number = fld;
        res.char_out = ch;
        str_field = 1'b1;
        gaps = 0;
        case (fld)
            FLD_NAME:    gaps = 0;
            FLD_PASSWD:  gaps = 1;
            FLD_COMMENT: gaps = 2;
            FLD_HOME:    gaps = 3;
            FLD_SHELL:   gaps = 4;
            default:     str_field = 1'b0;
        endcase
        if (ch == SEP_CHAR) begin
            if (rec_field != FLD_EXTRA)
                rec_field = rec_field + 1'b1;
        end else if (fld == FLD_UID) begin
            add_digit(ch, uid_acc, uid_digits);
        end else if (fld == FLD_GID) begin
            add_digit(ch, gid_acc, gid_digits);
        end else if (str_field && !(last && fld == FLD_SHELL && ch == NL_CHAR)) begin
            pos = 32'(str_total) + gaps;
            res.is_content = 1'b1;
            res.buffer_offset = (pos > 32'(OFFSET_MAX)) ? OFFSET_MAX : t_offset'(pos);
            if (str_total != TOTAL_MAX)
                str_total = str_total + 1'b1;
        end
        if (last) begin
            res.record_done = 1'b1;
            res.status = rec_bad || rec_field != COLONS_NEEDED ||
                         uid_digits > MAX_DIGITS || gid_digits > MAX_DIGITS ||
                         32'(str_total) + 32'(TERM_GAPS) >= 32'(buf_len);
            res.user_id = uid_acc;
            res.group_id = gid_acc;
            rec_field = FLD_NAME;
            str_total = '0;
            uid_acc = '0;
            gid_acc = '0;
            uid_digits = '0;
            gid_digits = '0;
            rec_bad = 1'b0;
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic quiet_tail();
        return final_phase && pending_bytes.size() < QUIET_ITEMS;
    endfunction

    // ---------------- record building ----------------

    task automatic draft_text(input string s);
        for (int k = 0; k < s.len(); k++)
            draft.push_back('{s[k], 1'b0});
    endtask

    task automatic close_draft();
        t_line_byte tail;
        if (draft.size() == 0)
            draft.push_back('{8'h41, 1'b0});
        tail = draft.pop_back();
        tail.last = 1'b1;
        draft.push_back(tail);
        foreach (draft[k])
            pending_bytes.push_back(draft[k]);
        draft.delete();
    endtask

    task automatic draft_string(input int unsigned len);
        t_byte ch;
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(0, 3) == 0)
                ch = t_byte'($urandom_range(0, 255));
            else
                ch = t_byte'($urandom_range(8'h61, 8'h7A));
            if (ch == SEP_CHAR)
                ch = 8'h5F;
            draft.push_back('{ch, 1'b0});
        end
    endtask

    task automatic draft_number();
        int unsigned roll;
        int unsigned digits;
        t_byte       ch;
        roll = $urandom_range(0, 15);
        digits = (roll < 2) ? $urandom_range(6, 8) : $urandom_range(0, 5);
        for (int unsigned k = 0; k < digits; k++) begin
            ch = (roll == 3) ? ASCII_NINE : t_byte'($urandom_range(ASCII_ZERO, ASCII_NINE));
            draft.push_back('{ch, 1'b0});
        end
        if (roll == 2) begin
            do
                ch = t_byte'($urandom_range(0, 255));
            while ((ch >= ASCII_ZERO && ch <= ASCII_NINE) || ch == SEP_CHAR);
            draft.insert($urandom_range(0, draft.size()), '{ch, 1'b0});
        end
    endtask

    task automatic draft_record();
        int unsigned style;
        int unsigned spot;
        style = $urandom_range(0, 9);
        if (style == 0) begin
            // line noise
            repeat ($urandom_range(1, 20))
                draft.push_back('{t_byte'($urandom_range(0, 255)), 1'b0});
        end else begin
            for (int fld = 0; fld < 7; fld++) begin
                if (fld == FLD_UID || fld == FLD_GID)
                    draft_number();
                else
                    draft_string(($urandom_range(0, 3) == 0) ? $urandom_range(7, 30)
                                                            : $urandom_range(0, 6));
                if (fld != FLD_SHELL)
                    draft_text(":");
            end
            if (style == 1) begin
                // one separator too many or too few
                spot = $urandom_range(0, draft.size() - 1);
                if ($urandom_range(0, 1)) begin
                    draft.insert(spot, '{SEP_CHAR, 1'b0});
                end else begin
                    for (int k = spot; k < draft.size(); k++) begin
                        if (draft[k].ch == SEP_CHAR) begin
                            draft.delete(k);
                            break;
                        end
                    end
                end
            end else if (style == 2) begin
                draft_text(":x");
            end
            if ($urandom_range(0, 1))
                draft_text("\n");
        end
        close_draft();
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned stop;
        stop = pending_bytes.size() + count;
        while (pending_bytes.size() < stop)
            draft_record();
    endtask

    // ---------------- phase control ----------------

    task automatic settle();
        do
            @(posedge clk);
        while (pending_bytes.size() != 0 || in_bus.valid || expected_results.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_buffer_length(input t_buflen value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.buffer_length <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        buf_len = value;
        @(negedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.char_in = '0;
        in_bus.line_last = 1'b0;
        out_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.buffer_length = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extreme bytes, largest uid, empty gid, dropped final newline
        draft.push_back('{8'hFF, 1'b0});
        draft_text(":");
        draft.push_back('{8'h00, 1'b0});
        draft_text(":99999::::\n");
        close_draft();
        // long uid, non-digit gid, seventh colon
        draft_text("::123456:7a::::Q");
        close_draft();
        // lone newline in the name field is content
        draft_text("\n");
        close_draft();
        settle();

        write_buffer_length(16'd0);
        queue_random(170);
        settle();

        // largest buffer length
        write_buffer_length(16'hFFFF);
        queue_random(130);
        settle();

        write_buffer_length(16'd20);
        queue_random(170);
        settle();

        write_buffer_length(t_buflen'($urandom_range(10, 60)));
        queue_random(170);
        settle();

        final_phase = 1'b1;
        write_buffer_length(BUFLEN_RESET);
        queue_random(270);
        settle();

        repeat (5) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // ---------------- byte driver ----------------

    always @(posedge clk) begin : byte_driver
        int unsigned gap_left;
        t_line_byte  nxt;
        if (!rst_n) begin
            gap_left = 0;
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready)
                expected_results.push_back(parse_byte(in_bus.char_in, in_bus.line_last));
            if (!in_bus.valid || in_bus.ready) begin
                if (gap_left != 0 && !quiet_tail()) begin
                    gap_left--;
                    in_bus.valid <= 1'b0;
                end else if (pending_bytes.size() != 0 && !quiet_tail() &&
                             $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 5);
                    in_bus.valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    gap_left = 0;
                    nxt = pending_bytes.pop_front();
                    in_bus.valid <= 1'b1;
                    in_bus.char_in <= nxt.ch;
                    in_bus.line_last <= nxt.last;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result monitor ----------------

    always @(posedge clk) begin : result_monitor
        int unsigned stall_left;
        t_result     want;
        if (!rst_n) begin
            stall_left = 0;
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, got char 0x%0h", $time,
                             out_bus.char_out);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("field_number", want.field_number, out_bus.field_number);
                    check_field("char_out", want.char_out, out_bus.char_out);
                    check_field("is_content", want.is_content, out_bus.is_content);
                    check_field("buffer_offset", want.buffer_offset, out_bus.buffer_offset);
                    check_field("record_done", want.record_done, out_bus.record_done);
                    check_field("status", want.status, out_bus.status);
                    check_field("user_id", want.user_id, out_bus.user_id);
                    check_field("group_id", want.group_id, out_bus.group_id);
                end
            end
            if (stall_left != 0 && !quiet_tail()) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else if (!quiet_tail() && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 5);
                out_bus.ready <= 1'b0;
            end else begin
                stall_left = 0;
                out_bus.ready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCH_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

FILE: sim.f
+incdir+sv
sv/cprf_pkg.sv
sv/cprf_in_if.sv
sv/cprf_out_if.sv
sv/cprf_cfg_if.sv
sv/colon_record_field_parser_top.sv
verif/testbench.sv
